// ===== rtl/wlrf_pkg.sv =====
// Shared types and constants for the weight-limited ring FIFO.
package wlrf_pkg;

   localparam int DEPTH     = 256;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CAP_W     = 9;
   localparam int CNT_W     = 9;
   localparam int WSUM_W    = 24;
   localparam int PAYLOAD_W = 32;
   localparam int WEIGHT_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 24;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CHECK = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_OVERWEIGHT = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_WEIGHT = 1'b0,
      CSR_CAPACITY   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [WEIGHT_W-1:0]  weight;
   } slot_type;

endpackage

// ===== rtl/wlrf_slot_ram.sv =====
// Slot storage: one write port, one read port, registered read data.
module wlrf_slot_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [wlrf_pkg::IDX_W-1:0]  wr_addr,
   input  wlrf_pkg::slot_type          wr_data,
   input  logic                        rd_en,
   input  logic [wlrf_pkg::IDX_W-1:0]  rd_addr,
   output wlrf_pkg::slot_type          rd_data
);

   wlrf_pkg::slot_type mem [wlrf_pkg::DEPTH];
   wlrf_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/weight_limited_ring_fifo_unit.sv =====
// Top level: weight-limited ring FIFO of loads with slot RAM and result register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | cmd, load_payload, load_weight
//   rsp     | out       | rsp_valid/ready    | status, load out, count, weight, flags
//   csr     | in        | csr_wr_en          | csr_index, csr_wr_data
//
// Each command is handled in order: the accept cycle issues the slot RAM read at the read
// index; once the result register is free, the command is applied (RAM write for push) and
// the result register is loaded from the registered RAM read data.
// A new beat is accepted while the previous result waits in the result register.
// A stalled result holds the executing command until the register frees.
// Synchronous reset: empty queue, limit and capacity at their maximum; no RAM clear.
module weight_limited_ring_fifo_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [wlrf_pkg::PAYLOAD_W-1:0]      req_load_payload,
   input  logic [wlrf_pkg::WEIGHT_W-1:0]       req_load_weight,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [wlrf_pkg::PAYLOAD_W-1:0]      rsp_out_payload,
   output logic [wlrf_pkg::WEIGHT_W-1:0]       rsp_out_weight,
   output logic [wlrf_pkg::CNT_W-1:0]          rsp_item_count,
   output logic [wlrf_pkg::WSUM_W-1:0]         rsp_weight_sum,
   output logic                                rsp_full_flag,
   output logic                                rsp_empty_flag,
   input  logic                                csr_wr_en,
   input  logic [wlrf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wlrf_pkg::CSR_DAT_W-1:0]      csr_wr_data
);

   localparam logic [wlrf_pkg::CAP_W-1:0] CapMax = wlrf_pkg::CAP_W'(wlrf_pkg::DEPTH);

   // configuration
   logic [wlrf_pkg::WSUM_W-1:0]    max_w_ff;
   logic [wlrf_pkg::CAP_W-1:0]     cap_ff;

   // queue state
   logic [wlrf_pkg::IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [wlrf_pkg::IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic [wlrf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [wlrf_pkg::WSUM_W-1:0]    wsum_ff, wsum_in;

   // executing command
   logic                           busy_ff;
   wlrf_pkg::cmd_type              cmd_ff;
   logic [wlrf_pkg::PAYLOAD_W-1:0] payload_ff;
   logic [wlrf_pkg::WEIGHT_W-1:0]  weight_ff;

   // result register
   logic                           rsp_valid_ff;
   wlrf_pkg::status_type           status_ff, status_in;
   logic [wlrf_pkg::PAYLOAD_W-1:0] opay_ff, opay_in;
   logic [wlrf_pkg::WEIGHT_W-1:0]  owt_ff, owt_in;
   logic [wlrf_pkg::CNT_W-1:0]     rcount_ff;
   logic [wlrf_pkg::WSUM_W-1:0]    rwsum_ff;
   logic                           full_ff, full_in;
   logic                           empty_ff;

   logic                           accept;
   logic                           done;
   logic [wlrf_pkg::CAP_W-1:0]     eff_cap;
   logic                           is_full;
   logic [wlrf_pkg::WSUM_W:0]      sum_try;
   wlrf_pkg::status_type           admit;
   logic                           ram_wr_en;
   wlrf_pkg::slot_type             ram_wr_data;
   wlrf_pkg::slot_type             ram_rd_data;
   logic [wlrf_pkg::CAP_W-1:0]     rd_next, wr_next;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign done      = busy_ff && (!rsp_valid_ff || rsp_ready);

   wlrf_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = wlrf_pkg::CAP_W'(1);
      end else if (cap_ff > CapMax) begin
         eff_cap = CapMax;
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign is_full = count_ff >= eff_cap;
   assign sum_try = {1'b0, wsum_ff} + (wlrf_pkg::WSUM_W+1)'(weight_ff);
   assign rd_next = wlrf_pkg::CAP_W'(rd_idx_ff) + wlrf_pkg::CAP_W'(1);
   assign wr_next = wlrf_pkg::CAP_W'(wr_idx_ff) + wlrf_pkg::CAP_W'(1);

   always_comb begin
      if (is_full) begin
         admit = wlrf_pkg::ST_FULL;
      end else if (sum_try > {1'b0, max_w_ff}) begin
         admit = wlrf_pkg::ST_OVERWEIGHT;
      end else begin
         admit = wlrf_pkg::ST_OK;
      end
   end

   assign ram_wr_data.payload = payload_ff;
   assign ram_wr_data.weight  = weight_ff;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      count_in  = count_ff;
      wsum_in   = wsum_ff;
      status_in = wlrf_pkg::ST_OK;
      opay_in   = '0;
      owt_in    = '0;
      ram_wr_en = 1'b0;
      case (cmd_ff)
         wlrf_pkg::CMD_PUSH: begin
            status_in = admit;
            if (admit == wlrf_pkg::ST_OK) begin
               ram_wr_en = done;
               wr_idx_in = (wr_next >= eff_cap) ? '0 : wr_next[wlrf_pkg::IDX_W-1:0];
               count_in  = count_ff + wlrf_pkg::CNT_W'(1);
               wsum_in   = sum_try[wlrf_pkg::WSUM_W-1:0];
            end
         end
         wlrf_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               status_in = wlrf_pkg::ST_EMPTY;
            end else begin
               opay_in   = ram_rd_data.payload;
               owt_in    = ram_rd_data.weight;
               rd_idx_in = (rd_next >= eff_cap) ? '0 : rd_next[wlrf_pkg::IDX_W-1:0];
               count_in  = count_ff - wlrf_pkg::CNT_W'(1);
               // saturate at zero on underflow
               wsum_in   = (wsum_ff >= wlrf_pkg::WSUM_W'(ram_rd_data.weight)) ?
                           wsum_ff - wlrf_pkg::WSUM_W'(ram_rd_data.weight) : '0;
            end
         end
         wlrf_pkg::CMD_CHECK: begin
            status_in = admit;
         end
         default: begin
            status_in = wlrf_pkg::ST_OK;
         end
      endcase
      full_in = count_in >= eff_cap;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_w_ff <= '1;
         cap_ff   <= CapMax;
      end else if (csr_wr_en) begin
         unique case (wlrf_pkg::csr_idx_type'(csr_index))
            wlrf_pkg::CSR_MAX_WEIGHT: max_w_ff <= csr_wr_data;
            wlrf_pkg::CSR_CAPACITY:   cap_ff   <= csr_wr_data[wlrf_pkg::CAP_W-1:0];
            default:                  ;
         endcase
      end
   end

   // control and queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         count_ff     <= '0;
         wsum_ff      <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done) begin
            rd_idx_ff <= rd_idx_in;
            wr_idx_ff <= wr_idx_in;
            count_ff  <= count_in;
            wsum_ff   <= wsum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= wlrf_pkg::cmd_type'(req_cmd);
         payload_ff <= req_load_payload;
         weight_ff  <= req_load_weight;
      end
      if (done) begin
         status_ff <= status_in;
         opay_ff   <= opay_in;
         owt_ff    <= owt_in;
         rcount_ff <= count_in;
         rwsum_ff  <= wsum_in;
         full_ff   <= full_in;
         empty_ff  <= count_in == '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_payload = opay_ff;
   assign rsp_out_weight  = owt_ff;
   assign rsp_item_count  = rcount_ff;
   assign rsp_weight_sum  = rwsum_ff;
   assign rsp_full_flag   = full_ff;
   assign rsp_empty_flag  = empty_ff;

endmodule
